// ----- src/rbsi_pkg.sv -----
// shared constants for the ray box slab intersection block
`default_nettype none
package rbsi_pkg;

	localparam int COORD_WIDTH_DEF = 32;
	localparam int FRAC_BITS_DEF   = 16;
	localparam int NUM_AXES        = 3;
	localparam int NUM_DIV         = 2 * NUM_AXES;

	// register indexes on the configuration port
	localparam logic [2:0] REG_BOX_MIN_X  = 3'd0;
	localparam logic [2:0] REG_BOX_MIN_Y  = 3'd1;
	localparam logic [2:0] REG_BOX_MIN_Z  = 3'd2;
	localparam logic [2:0] REG_BOX_MAX_X  = 3'd3;
	localparam logic [2:0] REG_BOX_MAX_Y  = 3'd4;
	localparam logic [2:0] REG_BOX_MAX_Z  = 3'd5;
	localparam logic [2:0] REG_NEAR_LIMIT = 3'd6;

	// box corner reset values in units of one half
	localparam int BOX_MIN_X_HALVES = -4;
	localparam int BOX_MIN_Y_HALVES = -1;
	localparam int BOX_MIN_Z_HALVES = -8;
	localparam int BOX_MAX_X_HALVES = 4;
	localparam int BOX_MAX_Y_HALVES = 2;
	localparam int BOX_MAX_Z_HALVES = 8;

	// normal component codes
	localparam logic [1:0] NORM_NONE = 2'b00;
	localparam logic [1:0] NORM_POS  = 2'b01;
	localparam logic [1:0] NORM_NEG  = 2'b11;

endpackage
`default_nettype wire

// ----- src/rbsi_ray_if.sv -----
// ray input channel
`default_nettype none
interface rbsi_ray_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic signed [COORD_WIDTH-1:0] org_x;
	logic signed [COORD_WIDTH-1:0] org_y;
	logic signed [COORD_WIDTH-1:0] org_z;
	logic signed [COORD_WIDTH-1:0] dir_x;
	logic signed [COORD_WIDTH-1:0] dir_y;
	logic signed [COORD_WIDTH-1:0] dir_z;
	logic        [COORD_WIDTH-2:0] best_t;

	modport source (output valid, org_x, org_y, org_z, dir_x, dir_y, dir_z, best_t,
		input ready);
	modport sink (input valid, org_x, org_y, org_z, dir_x, dir_y, dir_z, best_t,
		output ready);
endinterface
`default_nettype wire

// ----- src/rbsi_hit_if.sv -----
// hit result channel
`default_nettype none
interface rbsi_hit_if #(
	parameter int COORD_WIDTH = 32
);
	logic                          valid;
	logic                          ready;
	logic                          hit;
	logic signed [COORD_WIDTH-1:0] hit_dist;
	logic signed [1:0]             normal_x;
	logic signed [1:0]             normal_y;
	logic signed [1:0]             normal_z;

	modport source (output valid, hit, hit_dist, normal_x, normal_y, normal_z,
		input ready);
	modport sink (input valid, hit, hit_dist, normal_x, normal_y, normal_z,
		output ready);
endinterface
`default_nettype wire

// ----- src/ray_box_slab_intersect.sv -----
// ray against axis-aligned box test, slab method, deep pipeline
//
// rays come in on the ray channel, one transfer per cycle unless res stalls;
// each ray gives exactly one result transfer on the res channel with the
// hit flag, entry distance (or best_t when missed) and, on a hit, a unit normal.
// box corners and the near limit are written over the apb port; the user must
// write them only while no ray is in flight (the block does not enforce it).
// reads return the stored values. coordinates are Q16.16 by default. a ray
// passes one setup stage, one restoring division stage per quotient bit
// (COORD_WIDTH + FRAC_BITS + 1 of them, six dividers side by side), then
// quotient saturation, slab min/max, entry/exit over x and y, and the output
// register that folds in z and the hit decision, before result valid.
// throughput is one ray per cycle while the receiver does not stall.
// when the receiver stalls the whole pipeline holds, ray.ready drops in the
// same cycle, and nothing is lost or repeated.
// reset clears all valid bits and loads the default box (-2,-0.5,-4) to
// (2,1,4) with near limit 0.
`default_nettype none
module ray_box_slab_intersect
	import rbsi_pkg::*;
#(
	parameter int COORD_WIDTH = COORD_WIDTH_DEF,
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	localparam int PDW = (COORD_WIDTH > 32) ? 64 : 32,
	localparam int AST = (COORD_WIDTH > 32) ? 3 : 2,
	localparam int AW  = AST + 3
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	rbsi_ray_if.sink            ray,
	rbsi_hit_if.source          res,
	input  wire logic           psel,
	input  wire logic           penable,
	input  wire logic           pwrite,
	input  wire logic [AW-1:0]  paddr,
	input  wire logic [PDW-1:0] pwdata,
	output logic      [PDW-1:0] prdata,
	output logic                pready
);

	localparam int CW = COORD_WIDTH;
	localparam int FB = FRAC_BITS;
	localparam int NW = CW + 1;
	localparam int QW = NW + FB;

	localparam logic [CW-1:0] Q_MAX = {1'b0, {(CW-1){1'b1}}};
	localparam logic [CW-1:0] Q_MIN = {1'b1, {(CW-1){1'b0}}};

	typedef struct packed {
		logic [CW-2:0]          best;
		logic [NUM_AXES-1:0]    dpos;
		logic [NUM_AXES-1:0]    dzero;
		logic [NUM_DIV-1:0]     nneg;
		logic [NUM_DIV-1:0]     qneg;
	} meta_t;

	// ---------------- configuration ----------------
	logic signed [CW-1:0] box_min_q [NUM_AXES];
	logic signed [CW-1:0] box_max_q [NUM_AXES];
	logic signed [CW-1:0] near_q;
	logic        [2:0]    reg_idx;
	logic                 cfg_wr;

	assign pready  = 1'b1;
	assign reg_idx = paddr[AW-1:AST];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_min_q[0] <= CW'(64'(BOX_MIN_X_HALVES) <<< (FB - 1));
			box_min_q[1] <= CW'(64'(BOX_MIN_Y_HALVES) <<< (FB - 1));
			box_min_q[2] <= CW'(64'(BOX_MIN_Z_HALVES) <<< (FB - 1));
			box_max_q[0] <= CW'(64'(BOX_MAX_X_HALVES) <<< (FB - 1));
			box_max_q[1] <= CW'(64'(BOX_MAX_Y_HALVES) <<< (FB - 1));
			box_max_q[2] <= CW'(64'(BOX_MAX_Z_HALVES) <<< (FB - 1));
			near_q       <= '0;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_BOX_MIN_X:  box_min_q[0] <= pwdata[CW-1:0];
				REG_BOX_MIN_Y:  box_min_q[1] <= pwdata[CW-1:0];
				REG_BOX_MIN_Z:  box_min_q[2] <= pwdata[CW-1:0];
				REG_BOX_MAX_X:  box_max_q[0] <= pwdata[CW-1:0];
				REG_BOX_MAX_Y:  box_max_q[1] <= pwdata[CW-1:0];
				REG_BOX_MAX_Z:  box_max_q[2] <= pwdata[CW-1:0];
				REG_NEAR_LIMIT: near_q       <= pwdata[CW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_BOX_MIN_X:  prdata = PDW'(box_min_q[0]);
			REG_BOX_MIN_Y:  prdata = PDW'(box_min_q[1]);
			REG_BOX_MIN_Z:  prdata = PDW'(box_min_q[2]);
			REG_BOX_MAX_X:  prdata = PDW'(box_max_q[0]);
			REG_BOX_MAX_Y:  prdata = PDW'(box_max_q[1]);
			REG_BOX_MAX_Z:  prdata = PDW'(box_max_q[2]);
			REG_NEAR_LIMIT: prdata = PDW'(near_q);
			default:        prdata = '0;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic en;
	logic out_vld_q;

	assign en        = !out_vld_q || res.ready;
	assign ray.ready = en;

	// ---------------- setup stage ----------------
	logic                 dv_vld_s  [QW+1];
	meta_t                dv_meta_s [QW+1];
	logic [CW-1:0]        dv_rem_s  [QW+1][NUM_DIV];
	logic [QW-1:0]        dv_dq_s   [QW+1][NUM_DIV];
	logic [CW-1:0]        dv_ud_s   [QW+1][NUM_DIV];

	logic signed [CW-1:0] org  [NUM_AXES];
	logic signed [CW-1:0] dir  [NUM_AXES];

	assign org[0] = ray.org_x;
	assign org[1] = ray.org_y;
	assign org[2] = ray.org_z;
	assign dir[0] = ray.dir_x;
	assign dir[1] = ray.dir_y;
	assign dir[2] = ray.dir_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_vld_s[0] <= 1'b0;
		end else if (en) begin
			dv_vld_s[0] <= ray.valid;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [NW-1:0] num;
		logic        [NW-1:0] un;
		logic        [CW-1:0] ud;
		logic                 dneg;
		if (en) begin
			dv_meta_s[0].best <= ray.best_t;
			for (int a = 0; a < NUM_AXES; a++) begin
				dneg = dir[a][CW-1];
				ud   = dneg ? CW'(-dir[a]) : dir[a];
				dv_meta_s[0].dpos[a]  <= !dneg && (dir[a] != '0);
				dv_meta_s[0].dzero[a] <= (dir[a] == '0);
				for (int h = 0; h < 2; h++) begin
					// even slot is the min corner, odd slot the max corner
					num = (h == 0) ? (NW'(box_min_q[a]) - NW'(org[a]))
					               : (NW'(box_max_q[a]) - NW'(org[a]));
					un  = num[NW-1] ? NW'(-num) : num;
					dv_meta_s[0].nneg[2*a+h] <= num[NW-1];
					dv_meta_s[0].qneg[2*a+h] <= num[NW-1] ^ dneg;
					dv_rem_s[0][2*a+h] <= '0;
					dv_dq_s[0][2*a+h]  <= {un, {FB{1'b0}}};
					dv_ud_s[0][2*a+h]  <= ud;
				end
			end
		end
	end

	// ---------------- restoring division, one quotient bit per stage ----------------
	for (genvar k = 0; k < QW; k++) begin : g_div
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[k+1] <= 1'b0;
			end else if (en) begin
				dv_vld_s[k+1] <= dv_vld_s[k];
			end
		end

		always_ff @(posedge clk) begin
			logic [CW:0] t;
			logic        ge;
			if (en) begin
				dv_meta_s[k+1] <= dv_meta_s[k];
				for (int j = 0; j < NUM_DIV; j++) begin
					t  = {dv_rem_s[k][j], dv_dq_s[k][j][QW-1]};
					ge = (t >= {1'b0, dv_ud_s[k][j]});
					dv_rem_s[k+1][j] <= ge ? CW'(t - {1'b0, dv_ud_s[k][j]}) : t[CW-1:0];
					dv_dq_s[k+1][j]  <= {dv_dq_s[k][j][QW-2:0], ge};
					dv_ud_s[k+1][j]  <= dv_ud_s[k][j];
				end
			end
		end
	end

	// ---------------- sign and saturation ----------------
	logic                 vld_sq;
	meta_t                meta_sq;
	logic signed [CW-1:0] quot_sq [NUM_DIV];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sq <= 1'b0;
		end else if (en) begin
			vld_sq <= dv_vld_s[QW];
		end
	end

	always_ff @(posedge clk) begin
		logic [QW-1:0] q;
		logic          sat;
		logic          neg;
		if (en) begin
			meta_sq <= dv_meta_s[QW];
			for (int j = 0; j < NUM_DIV; j++) begin
				q   = dv_dq_s[QW][j];
				neg = dv_meta_s[QW].qneg[j];
				sat = (|q[QW-1:CW]) || (neg ? (q[CW-1:0] > Q_MIN) : (q[CW-1:0] > Q_MAX));
				if (dv_meta_s[QW].dzero[j/2]) begin
					quot_sq[j] <= dv_meta_s[QW].nneg[j] ? Q_MIN : Q_MAX;
				end else if (sat) begin
					quot_sq[j] <= neg ? Q_MIN : Q_MAX;
				end else begin
					quot_sq[j] <= neg ? CW'(-q[CW-1:0]) : q[CW-1:0];
				end
			end
		end
	end

	// ---------------- slab near and far ----------------
	logic                 vld_st;
	meta_t                meta_st;
	logic signed [CW-1:0] tn_st [NUM_AXES];
	logic signed [CW-1:0] tf_st [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_st <= 1'b0;
		end else if (en) begin
			vld_st <= vld_sq;
		end
	end

	always_ff @(posedge clk) begin
		logic lt;
		if (en) begin
			meta_st <= meta_sq;
			for (int a = 0; a < NUM_AXES; a++) begin
				lt = quot_sq[2*a] < quot_sq[2*a+1];
				tn_st[a] <= lt ? quot_sq[2*a]   : quot_sq[2*a+1];
				tf_st[a] <= lt ? quot_sq[2*a+1] : quot_sq[2*a];
			end
		end
	end

	// ---------------- entry and exit over x and y ----------------
	logic                 vld_sa;
	meta_t                meta_sa;
	logic signed [CW-1:0] t0_sa;
	logic signed [CW-1:0] t1_sa;
	logic        [1:0]    axis_sa;
	logic signed [CW-1:0] tn2_sa;
	logic signed [CW-1:0] tf2_sa;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sa <= 1'b0;
		end else if (en) begin
			vld_sa <= vld_st;
		end
	end

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] t0;
		logic signed [CW-1:0] t1;
		logic        [1:0]    ax;
		if (en) begin
			t0 = near_q;
			t1 = CW'(meta_st.best);
			ax = 2'd0;
			for (int a = 0; a < 2; a++) begin
				if (t0 < tn_st[a]) begin
					t0 = tn_st[a];
					ax = 2'(a);
				end
				if (tf_st[a] < t1) begin
					t1 = tf_st[a];
				end
			end
			meta_sa <= meta_st;
			t0_sa   <= t0;
			t1_sa   <= t1;
			axis_sa <= ax;
			tn2_sa  <= tn_st[2];
			tf2_sa  <= tf_st[2];
		end
	end

	// ---------------- z axis, hit decision, output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_sa;
		end
	end

	logic                 hit_q;
	logic signed [CW-1:0] dist_q;
	logic        [1:0]    nx_q;
	logic        [1:0]    ny_q;
	logic        [1:0]    nz_q;

	always_ff @(posedge clk) begin
		logic signed [CW-1:0] t0;
		logic signed [CW-1:0] t1;
		logic        [1:0]    ax;
		logic                 h;
		logic        [1:0]    nc;
		if (en) begin
			t0 = t0_sa;
			t1 = t1_sa;
			ax = axis_sa;
			if (t0 < tn2_sa) begin
				t0 = tn2_sa;
				ax = 2'd2;
			end
			if (tf2_sa < t1) begin
				t1 = tf2_sa;
			end
			h  = t0 < t1;
			nc = meta_sa.dpos[ax] ? NORM_NEG : NORM_POS;
			hit_q  <= h;
			dist_q <= h ? t0 : CW'(meta_sa.best);
			nx_q   <= (h && ax == 2'd0) ? nc : NORM_NONE;
			ny_q   <= (h && ax == 2'd1) ? nc : NORM_NONE;
			nz_q   <= (h && ax == 2'd2) ? nc : NORM_NONE;
		end
	end

	assign res.valid    = out_vld_q;
	assign res.hit      = hit_q;
	assign res.hit_dist = dist_q;
	assign res.normal_x = nx_q;
	assign res.normal_y = ny_q;
	assign res.normal_z = nz_q;

`ifndef SYNTHESIS
	// a hit carries exactly one nonzero normal component
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.hit |->
		$countones({nx_q != NORM_NONE, ny_q != NORM_NONE, nz_q != NORM_NONE}) == 1)
	else $error("hit without a single normal axis");

	// a miss carries a zero normal and a nonnegative distance
	assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.hit |->
		nx_q == NORM_NONE && ny_q == NORM_NONE && nz_q == NORM_NONE && !dist_q[CW-1])
	else $error("miss with nonzero normal or negative distance");

	// a stall freezes the setup stage and x/y entry stage valid bits
	assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(dv_vld_s[0]) && $stable(vld_sa))
	else $error("pipeline moved during a stall");
`endif

endmodule
`default_nettype wire

// ----- bench/testbench.sv -----
// self-checking testbench for the ray box slab intersection block
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import rbsi_pkg::*;

	localparam int CW = 32;
	localparam int FB = 16;
	localparam longint Q_MAX = 64'sd2147483647;
	localparam longint Q_MIN = -64'sd2147483648;
	localparam longint ONE = 64'sd65536;
	localparam int PIPE_DEPTH = CW + FB + 6;
	localparam int CYCLE_LIMIT = 600000;
	localparam int MAX_REPORTS = 10;

	typedef struct packed {
		logic signed [CW-1:0] org_x, org_y, org_z;
		logic signed [CW-1:0] dir_x, dir_y, dir_z;
		logic [CW-2:0] best_t;
	} ray_t;

	typedef struct packed {
		logic hit;
		logic signed [CW-1:0] t_hit;
		logic signed [1:0] nx, ny, nz;
	} hit_t;

	logic clk;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [4:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	rbsi_ray_if #(.COORD_WIDTH(CW)) ray ();
	rbsi_hit_if #(.COORD_WIDTH(CW)) res ();

	ray_box_slab_intersect dut (
		.clk(clk), .arst_n(arst_n), .ray(ray.sink), .res(res.source),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// predictor copy of the register file
	longint box_lo[3];
	longint box_hi[3];
	longint near_lim;

	hit_t pending_hits[$];
	int rays_sent, hits_checked, mismatches, hit_count, cycles;
	int hold_cycles;
	bit no_gaps;

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_hits.size());
			$display("testbench: done, errors");
			$finish;
		end
	end

	// fixed point slab distance with saturation
	function automatic longint slab_div(longint num, longint den);
		bit neg;
		longint un, ud, q, lim;
		if (den == 0)
			return (num < 0) ? Q_MIN : Q_MAX;
		neg = (num < 0) != (den < 0);
		un = (num < 0) ? -num : num;
		ud = (den < 0) ? -den : den;
		lim = neg ? -Q_MIN : Q_MAX;
		q = (un <<< FB) / ud;
		if (q > lim)
			return neg ? Q_MIN : Q_MAX;
		return neg ? -q : q;
	endfunction

	function automatic hit_t trace_box(ray_t r);
		longint o[3], d[3];
		longint lo, hi, tn, tf, t_in, t_out;
		int axis;
		hit_t h;
		o[0] = r.org_x; o[1] = r.org_y; o[2] = r.org_z;
		d[0] = r.dir_x; d[1] = r.dir_y; d[2] = r.dir_z;
		t_in = near_lim;
		t_out = longint'({1'b0, r.best_t});
		axis = 0;
		for (int i = 0; i < 3; i++) begin
			lo = slab_div(box_lo[i] - o[i], d[i]);
			hi = slab_div(box_hi[i] - o[i], d[i]);
			tn = (lo < hi) ? lo : hi;
			tf = (lo < hi) ? hi : lo;
			if (t_in < tn) begin
				t_in = tn;
				axis = i;
			end
			if (tf < t_out)
				t_out = tf;
		end
		h = '0;
		if (t_in < t_out) begin
			h.hit = 1'b1;
			h.t_hit = t_in[CW-1:0];
			case (axis)
				0: h.nx = (d[0] > 0) ? NORM_NEG : NORM_POS;
				1: h.ny = (d[1] > 0) ? NORM_NEG : NORM_POS;
				default: h.nz = (d[2] > 0) ? NORM_NEG : NORM_POS;
			endcase
		end else begin
			h.t_hit = {1'b0, r.best_t};
		end
		return h;
	endfunction

	// result checker
	always @(posedge clk) begin
		hit_t got, want;
		if (arst_n && res.valid && res.ready) begin
			got = {res.hit, res.hit_dist, res.normal_x, res.normal_y, res.normal_z};
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("unexpected result transfer: %p", got);
			end else begin
				want = pending_hits.pop_front();
				hits_checked++;
				if (got.hit)
					hit_count++;
				if (got !== want) begin
					mismatches++;
					if (mismatches <= MAX_REPORTS)
						$display("result %0d mismatch: expected %p, got %p",
							hits_checked, want, got);
				end
			end
		end
	end

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (roll < 60)
			return 0;
		if (roll < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 10);
	endfunction

	// receiver with random stalls and a counted hold-off
	initial begin
		int busy;
		busy = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				hold_cycles--;
				res.ready = 1'b0;
			end else if (busy > 0) begin
				busy--;
				res.ready = 1'b0;
			end else begin
				res.ready = 1'b1;
				if (!no_gaps)
					busy = pick_gap();
			end
		end
	end

	task automatic send_ray(ray_t r);
		int gap;
		@(negedge clk);
		{ray.org_x, ray.org_y, ray.org_z, ray.dir_x, ray.dir_y, ray.dir_z,
			ray.best_t} = r;
		ray.valid = 1'b1;
		do
			@(posedge clk);
		while (!ray.ready);
		pending_hits.push_back(trace_box(r));
		rays_sent++;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			ray.valid = 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	task automatic drain();
		@(negedge clk);
		ray.valid = 1'b0;
		while (pending_hits.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_write(logic [2:0] idx, longint value);
		logic [31:0] rd;
		@(negedge clk);
		psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
		paddr = {idx, 2'b00};
		pwdata = value[31:0];
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		pwrite = 1'b0; penable = 1'b0;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		rd = prdata;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0;
		if (rd !== value[31:0]) begin
			mismatches++;
			if (mismatches <= MAX_REPORTS)
				$display("register %0d readback: expected %h, got %h", idx, value[31:0], rd);
		end
		if (idx < REG_BOX_MAX_X)
			box_lo[idx] = longint'(signed'(value[31:0]));
		else if (idx < REG_NEAR_LIMIT)
			box_hi[idx - REG_BOX_MAX_X] = longint'(signed'(value[31:0]));
		else
			near_lim = longint'(signed'(value[31:0]));
	endtask

	task automatic load_box(longint lx, longint ly, longint lz,
			longint hx, longint hy, longint hz, longint nl);
		apb_write(REG_BOX_MIN_X, lx);
		apb_write(REG_BOX_MIN_Y, ly);
		apb_write(REG_BOX_MIN_Z, lz);
		apb_write(REG_BOX_MAX_X, hx);
		apb_write(REG_BOX_MAX_Y, hy);
		apb_write(REG_BOX_MAX_Z, hz);
		apb_write(REG_NEAR_LIMIT, nl);
	endtask

	function automatic ray_t make_ray(longint ox, longint oy, longint oz,
			longint dx, longint dy, longint dz, longint bt);
		ray_t r;
		r.org_x = ox[31:0]; r.org_y = oy[31:0]; r.org_z = oz[31:0];
		r.dir_x = dx[31:0]; r.dir_y = dy[31:0]; r.dir_z = dz[31:0];
		r.best_t = bt[30:0];
		return r;
	endfunction

	function automatic longint rand_coord(int span);
		return longint'($urandom_range(2 * span * 65536)) - longint'(span) * ONE;
	endfunction

	// mostly rays aimed at a point in or near the box, the rest raw bits
	function automatic ray_t random_ray();
		ray_t r;
		longint o[3], d[3], aim, bt;
		int sh, roll;
		roll = $urandom_range(99);
		if (roll < 20) begin
			r = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				31'($urandom)};
			return r;
		end
		sh = $urandom_range(4);
		for (int i = 0; i < 3; i++) begin
			o[i] = rand_coord(12);
			aim = box_lo[i] + longint'($urandom_range(100)) * ((box_hi[i] - box_lo[i]) / 100);
			d[i] = (aim - o[i]) >>> sh;
			if ($urandom_range(9) == 0)
				d[i] = 0;
			else if ($urandom_range(9) == 0)
				d[i] = -d[i];
		end
		case ($urandom_range(3))
			0: bt = Q_MAX;
			1: bt = $urandom_range(30) * ONE;
			2: bt = $urandom_range(32'h7fff_ffff);
			default: bt = $urandom_range(3) * ONE;
		endcase
		return make_ray(o[0], o[1], o[2], d[0], d[1], d[2], bt);
	endfunction

	task automatic test_directed();
		load_box(-131072, -32768, -262144, 131072, 65536, 262144, 0);
		// straight on along each axis, both senses
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, Q_MAX));
		send_ray(make_ray(5 * ONE, 0, 0, -ONE, 0, 0, Q_MAX));
		send_ray(make_ray(0, -5 * ONE, 0, 0, ONE, 0, Q_MAX));
		send_ray(make_ray(0, 5 * ONE, 0, 0, -2 * ONE, 0, Q_MAX));
		send_ray(make_ray(0, 0, -9 * ONE, 0, 0, ONE, Q_MAX));
		send_ray(make_ray(0, 0, 9 * ONE, 0, 0, -ONE, Q_MAX));
		// origin inside, entry never raised
		send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, Q_MAX));
		// closer hit already known
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 2 * ONE));
		send_ray(make_ray(-5 * ONE, 0, 0, ONE, 0, 0, 0));
		// miss, zero direction outside the slab
		send_ray(make_ray(-5 * ONE, 3 * ONE, 0, ONE, 0, 0, Q_MAX));
		// origin on a face with zero direction: zero numerator
		send_ray(make_ray(-5 * ONE, 65536, 0, ONE, 0, 0, Q_MAX));
		send_ray(make_ray(-5 * ONE, -32768, 0, ONE, 0, 0, Q_MAX));
		// all zero direction
		send_ray(make_ray(0, 0, 0, 0, 0, 0, Q_MAX));
		// field extremes
		send_ray(make_ray(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MAX));
		send_ray(make_ray(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, 0));
		send_ray(make_ray(Q_MIN, 0, Q_MAX, 1, -1, Q_MIN, Q_MAX));
		send_ray(make_ray(-5 * ONE, 0, 0, 1, 0, 0, Q_MAX));
		send_ray(make_ray(-ONE, 0, 0, -1, 0, 0, Q_MAX));
		drain();
		// negative near limit lets the entry distance go below zero
		apb_write(REG_NEAR_LIMIT, -10 * ONE);
		send_ray(make_ray(0, 0, 0, ONE, ONE, ONE, Q_MAX));
		send_ray(make_ray(0, 0, 0, 0, 0, 0, Q_MAX));
		send_ray(make_ray(-5 * ONE, 0, 0, -ONE, 0, 0, Q_MAX));
		drain();
	endtask

	task automatic test_register_extremes();
		load_box(Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
		repeat (40) send_ray(random_ray());
		drain();
		load_box(Q_MAX, Q_MAX, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX);
		repeat (40) send_ray(random_ray());
		drain();
	endtask

	task automatic test_random_boxes(int phases, int per_phase);
		longint lo[3], sz[3];
		for (int p = 0; p < phases; p++) begin
			for (int i = 0; i < 3; i++) begin
				lo[i] = rand_coord(6);
				sz[i] = longint'($urandom_range(8 * 65536));
			end
			load_box(lo[0], lo[1], lo[2], lo[0] + sz[0], lo[1] + sz[1], lo[2] + sz[2],
				($urandom_range(3) == 0) ? -rand_coord(2) : 0);
			no_gaps = (p % 3 == 2);
			repeat (per_phase) send_ray(random_ray());
			drain();
		end
		no_gaps = 1'b0;
	endtask

	task automatic test_backpressure();
		load_box(-131072, -32768, -262144, 131072, 65536, 262144, 0);
		no_gaps = 1'b1;
		hold_cycles = 300;
		repeat (150) send_ray(random_ray());
		no_gaps = 1'b0;
		// sender pauses until the pipe has emptied, then resumes
		drain();
		repeat (60) send_ray(random_ray());
		drain();
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		ray.valid = 1'b0;
		{ray.org_x, ray.org_y, ray.org_z, ray.dir_x, ray.dir_y, ray.dir_z, ray.best_t} = '0;
		hold_cycles = 0;
		no_gaps = 1'b0;
		cycles = 0;
		rays_sent = 0; hits_checked = 0; mismatches = 0; hit_count = 0;
		box_lo = '{-131072, -32768, -262144};
		box_hi = '{131072, 65536, 262144};
		near_lim = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_register_extremes();
		test_random_boxes(12, 75);
		test_backpressure();

		drain();
		repeat (PIPE_DEPTH + 10) @(posedge clk);
		$display("covered %0d rays over directed, extreme-register, random-box and",
			rays_sent);
		$display("stall phases; %0d results checked, %0d of them hits", hits_checked,
			hit_count);
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("%0d mismatches, %0d results missing", mismatches, pending_hits.size());
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule
`default_nettype wire
